FILE: sv/calu_pkg.sv
package calu_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_AND  = 4'd2,
		OP_OR   = 4'd3,
		OP_XOR  = 4'd4,
		OP_CMP  = 4'd5,
		OP_ROL  = 4'd6,
		OP_ROR  = 4'd7,
		OP_INC  = 4'd8,
		OP_DEC  = 4'd9,
		OP_LOAD = 4'd10
	} op_t;

	localparam logic [9:0] DEC_LIMIT    = 10'h099;
	localparam logic [9:0] DEC_HIGH_ADJ = 10'h060;
	localparam logic [9:0] DEC_LOW_ADJ  = 10'h006;
	localparam logic [4:0] NIBBLE_MAX   = 5'd9;
	localparam logic [7:0] ROR_Z_MASK   = 8'hFE;

	typedef struct packed {
		op_t        operation;
		logic [7:0] lhs;
		logic [7:0] rhs;
		logic       carry_in;
		logic       overflow_in;
		logic       decimal_mode;
	} alu_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic       negative;
		logic       overflow;
		logic       zero;
		logic       carry_out;
	} alu_out_t;

endpackage

FILE: sv/calu_core.sv
module calu_core import calu_pkg::*; (
	input  alu_in_t  op_in,
	output alu_out_t op_out
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic        borrow;
	logic [4:0]  add_lo;
	logic [9:0]  add_s0;
	logic [9:0]  add_s1;
	logic [9:0]  add_s2;
	logic [4:0]  sub_lo;
	logic [10:0] sub_d0;
	logic [10:0] sub_d1;
	logic [10:0] sub_d2;
	logic [7:0]  res;

	always_comb begin
		a      = op_in.lhs;
		b      = op_in.rhs;
		cin    = op_in.carry_in;
		borrow = ~cin;

		// decimal add: low fix first, V and N sampled before the high fix
		add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
		add_s0 = {2'b0, a} + {2'b0, b} + {9'd0, cin};
		add_s1 = (op_in.decimal_mode && add_lo > NIBBLE_MAX) ? add_s0 + DEC_LOW_ADJ : add_s0;
		add_s2 = (op_in.decimal_mode && add_s1 > DEC_LIMIT) ? add_s1 + DEC_HIGH_ADJ : add_s1;

		// signed 11-bit difference; bit 10 is the sign
		sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, borrow};
		sub_d0 = {3'b0, a} - {3'b0, b} - {10'd0, borrow};
		sub_d1 = (op_in.decimal_mode && sub_lo[4]) ? sub_d0 - {1'b0, DEC_LOW_ADJ} : sub_d0;
		sub_d2 = (op_in.decimal_mode && sub_d1[10]) ? sub_d1 - {1'b0, DEC_HIGH_ADJ} : sub_d1;

		op_out.overflow  = op_in.overflow_in;
		op_out.carry_out = cin;
		res              = a;

		unique case (op_in.operation)
			OP_ADD:  res = add_s2[7:0];
			OP_SUB:  res = sub_d2[7:0];
			OP_AND:  res = a & b;
			OP_OR:   res = a | b;
			OP_XOR:  res = a ^ b;
			OP_CMP:  res = a - b;
			OP_ROL:  res = {a[6:0], cin};
			OP_ROR:  res = {cin, a[7:1]};
			OP_INC:  res = a + 8'd1;
			OP_DEC:  res = a - 8'd1;
			OP_LOAD: res = b;
			default: res = a;
		endcase

		op_out.result   = res;
		op_out.negative = res[7];
		op_out.zero     = (res == 8'd0);

		unique case (op_in.operation)
			OP_ADD: begin
				op_out.overflow  = ~(a[7] ^ b[7]) & (a[7] ^ add_s1[7]);
				op_out.negative  = add_s1[7];
				op_out.carry_out = (add_s2[9:8] != 2'd0);
			end
			OP_SUB: begin
				op_out.overflow  = (a[7] ^ b[7]) & (a[7] ^ sub_d2[7]);
				op_out.carry_out = ~sub_d2[10];
			end
			OP_CMP:  op_out.carry_out = (a >= b);
			OP_ROL:  op_out.carry_out = a[7];
			OP_ROR: begin
				// N is the incoming carry, Z looks at the old byte with bit 0 = carry
				op_out.negative  = cin;
				op_out.zero      = (((a & ROR_Z_MASK) | {7'd0, cin}) == 8'd0);
				op_out.carry_out = a[0];
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/cpu_alu_with_decimal_adjust_top.sv
// 6502-style byte ALU with BCD adjust for add and subtract.
// Input channel: in_valid / in_ready / in_data (operation, operands, C, V, D).
// Output channel: out_valid / out_ready / out_data (result byte, N, V, Z, C).
// Every accepted word yields exactly one result word, in order.
// Two register stages: an input register and a result register with the
// ALU logic between them. An accepted word moves on into the result register
// once that is free and is on out_data from then on. Rate: one word per cycle
// while out_ready is high; the input register can fill while the result holds.
// in_ready is high while the input register is empty or can move on (result
// register empty or being taken), so a word is still accepted while a
// finished result waits.
// When out_ready is low the result holds, then the input register fills,
// and then in_ready drops until the output drains.
// Reset (arst_n low) empties both stages; no words are in flight after it.
// The block holds no architectural state: flags come in with each word.
module cpu_alu_with_decimal_adjust_top import calu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  alu_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output alu_out_t out_data
);

	logic     valid_s1;
	alu_in_t  data_s1;
	logic     valid_s2;
	alu_out_t data_s2;
	alu_out_t alu_res;
	logic     s2_free;
	logic     adv_s1;

	assign s2_free  = ~valid_s2 | out_ready;
	assign adv_s1   = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	calu_core u_core (
		.op_in  (data_s1),
		.op_out (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= alu_res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// input side only stalls when both stages are full and the output is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a full pipe");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("word advanced but no result shown");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1 && $stable(data_s1))
		else $error("held input word lost or changed");

endmodule
